### design/pftt_pkg.sv
package pftt_pkg;

  localparam int MAX_FLOWS = 64;
  localparam int CONN_BITS = 16;

  localparam int FLOW_W  = 6;
  localparam int TIME_W  = 64;
  localparam int TAG_W   = 16;
  localparam int STORE_W = (CONN_BITS < TAG_W) ? CONN_BITS : TAG_W;
  localparam int IDX_W   = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
  localparam int CNT_W   = $clog2(MAX_FLOWS + 1);
  localparam int ENTRY_W = 2 * TIME_W + STORE_W;

  typedef enum logic [1:0] {
    REQ_TIME   = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_STOP   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic               hit;
    logic               flush;
    logic [FLOW_W-1:0]  flow;
    logic [STORE_W-1:0] conn;
  } tick_evt_t;

  typedef struct packed {
    logic hit_ok;
    logic flush_done;
  } buf_stat_t;

endpackage

### design/pftt_if.sv
interface pftt_req_if import pftt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        req_type;
  logic [FLOW_W-1:0] flow_index;
  logic [TIME_W-1:0] period_ns;
  logic [TIME_W-1:0] now_ns;
  logic [TAG_W-1:0]  conn_tag;

  modport source (output valid, req_type, flow_index, period_ns, now_ns, conn_tag,
                  input ready);
  modport sink   (input valid, req_type, flow_index, period_ns, now_ns, conn_tag,
                  output ready);
endinterface

interface pftt_tick_if import pftt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FLOW_W-1:0] tick_flow;
  logic [TAG_W-1:0]  tick_conn;
  logic              last_tick;

  modport source (output valid, tick_flow, tick_conn, last_tick, input ready);
  modport sink   (input valid, tick_flow, tick_conn, last_tick, output ready);
endinterface

### design/pftt_ram.sv
module pftt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/pftt_tick_buf.sv
module pftt_tick_buf import pftt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tick_evt_t  evt_i,
  output buf_stat_t  stat_o,
  pftt_tick_if.source tick_o
);

  logic               pend_vld_q, pend_vld_d;
  logic [FLOW_W-1:0]  pend_flow_q, pend_flow_d;
  logic [STORE_W-1:0] pend_conn_q, pend_conn_d;
  logic               out_vld_q, out_vld_d;
  logic [FLOW_W-1:0]  out_flow_q, out_flow_d;
  logic [STORE_W-1:0] out_conn_q, out_conn_d;
  logic               out_last_q, out_last_d;
  logic               out_free;

  assign out_free = !out_vld_q || tick_o.ready;
  assign stat_o.hit_ok = !(pend_vld_q && !out_free);
  assign stat_o.flush_done = evt_i.flush && (!pend_vld_q || out_free);

  always_comb begin
    pend_vld_d  = pend_vld_q;
    pend_flow_d = pend_flow_q;
    pend_conn_d = pend_conn_q;
    out_vld_d   = out_vld_q && !tick_o.ready;
    out_flow_d  = out_flow_q;
    out_conn_d  = out_conn_q;
    out_last_d  = out_last_q;
    if (evt_i.hit && stat_o.hit_ok) begin
      if (pend_vld_q) begin
        out_vld_d  = 1'b1;
        out_flow_d = pend_flow_q;
        out_conn_d = pend_conn_q;
        out_last_d = 1'b0;
      end
      pend_vld_d  = 1'b1;
      pend_flow_d = evt_i.flow;
      pend_conn_d = evt_i.conn;
    end else if (evt_i.flush && pend_vld_q && out_free) begin
      out_vld_d  = 1'b1;
      out_flow_d = pend_flow_q;
      out_conn_d = pend_conn_q;
      out_last_d = 1'b1;
      pend_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_flow_q <= pend_flow_d;
    pend_conn_q <= pend_conn_d;
    out_flow_q  <= out_flow_d;
    out_conn_q  <= out_conn_d;
    out_last_q  <= out_last_d;
  end

  assign tick_o.valid     = out_vld_q;
  assign tick_o.tick_flow = out_flow_q;
  assign tick_o.tick_conn = TAG_W'(out_conn_q);
  assign tick_o.last_tick = out_last_q;

endmodule

### design/pftt_ctrl.sv
module pftt_ctrl import pftt_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  pftt_req_if.sink           req_i,
  output logic               ram_we_o,
  output logic [IDX_W-1:0]   ram_waddr_o,
  output logic [ENTRY_W-1:0] ram_wdata_o,
  output logic               ram_re_o,
  output logic [IDX_W-1:0]   ram_raddr_o,
  input  logic [ENTRY_W-1:0] ram_rdata_i,
  output tick_evt_t          evt_o,
  input  buf_stat_t          stat_i
);

  state_e              state_q, state_d;
  logic [MAX_FLOWS-1:0] valid_q, valid_d;
  logic                halted_q, halted_d;
  logic [TIME_W-1:0]   now_q, now_d;
  logic [CNT_W-1:0]    rd_cnt_q, rd_cnt_d;
  logic                ev_vld_q, ev_vld_d;
  logic [IDX_W-1:0]    ev_idx_q, ev_idx_d;

  logic                accept;
  logic                in_range;
  logic [IDX_W-1:0]    req_idx;
  logic [TIME_W-1:0]   rd_period;
  logic [TIME_W-1:0]   rd_deadline;
  logic [STORE_W-1:0]  rd_conn;
  logic                hit;
  logic                stall;
  logic                issue;
  logic                issued_all;

  assign accept      = req_i.valid && req_i.ready;
  assign in_range    = (FLOW_W+1)'(req_i.flow_index) < (FLOW_W+1)'(MAX_FLOWS);
  assign req_idx     = req_i.flow_index[IDX_W-1:0];
  assign rd_period   = ram_rdata_i[ENTRY_W-1 -: TIME_W];
  assign rd_deadline = ram_rdata_i[STORE_W +: TIME_W];
  assign rd_conn     = ram_rdata_i[STORE_W-1:0];
  assign issued_all  = rd_cnt_q == CNT_W'(MAX_FLOWS);

  assign hit   = (state_q == ST_SCAN) && ev_vld_q && valid_q[ev_idx_q] &&
                 (now_q >= rd_deadline);
  assign stall = hit && !stat_i.hit_ok;
  assign issue = (state_q == ST_SCAN) && !stall && !issued_all;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && req_i.req_type == REQ_TIME && !halted_q) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issued_all && !ev_vld_q) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (stat_i.flush_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    req_i.ready = state_q == ST_IDLE;
    ram_we_o    = 1'b0;
    ram_waddr_o = req_idx;
    ram_wdata_o = {req_i.period_ns, req_i.now_ns + req_i.period_ns,
                   req_i.conn_tag[STORE_W-1:0]};
    ram_re_o    = issue;
    ram_raddr_o = rd_cnt_q[IDX_W-1:0];
    evt_o.hit   = hit;
    evt_o.flush = state_q == ST_FLUSH;
    evt_o.flow  = FLOW_W'(ev_idx_q);
    evt_o.conn  = rd_conn;
    valid_d     = valid_q;
    halted_d    = halted_q;
    now_d       = now_q;
    rd_cnt_d    = rd_cnt_q;
    ev_vld_d    = ev_vld_q;
    ev_idx_d    = ev_idx_q;
    unique case (state_q)
      ST_IDLE: begin
        now_d    = req_i.now_ns;
        rd_cnt_d = '0;
        ev_vld_d = 1'b0;
        if (accept) begin
          unique case (req_i.req_type)
            REQ_ADD: begin
              if (in_range && req_i.period_ns != '0) begin
                ram_we_o         = 1'b1;
                valid_d[req_idx] = 1'b1;
              end
            end
            REQ_REMOVE: begin
              if (in_range) begin
                valid_d[req_idx] = 1'b0;
              end
            end
            REQ_STOP: halted_d = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        ram_waddr_o = ev_idx_q;
        ram_wdata_o = {rd_period, rd_deadline + rd_period, rd_conn};
        ram_we_o    = hit && stat_i.hit_ok;
        if (!stall) begin
          ev_vld_d = issue;
          ev_idx_d = rd_cnt_q[IDX_W-1:0];
          if (issue) begin
            rd_cnt_d = rd_cnt_q + 1'b1;
          end
        end
      end
      ST_FLUSH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      valid_q  <= '0;
      halted_q <= 1'b0;
      rd_cnt_q <= '0;
      ev_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      valid_q  <= valid_d;
      halted_q <= halted_d;
      rd_cnt_q <= rd_cnt_d;
      ev_vld_q <= ev_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q    <= now_d;
    ev_idx_q <= ev_idx_d;
  end

endmodule

### design/periodic_flow_timer_table.sv
// add, remove and stop leave the block idle; the next request is taken in the next cycle
// a time check reads one table entry per cycle from the entry memory, but stalls while an
// expired entry waits on a held-back tick output; requests wait until scan and flush end
// each tick is held back until the next expired entry is found or the scan ends, since its
// last flag is known only then
// reset clears the valid bits and the stop flag at once; no clearing pass
module periodic_flow_timer_table import pftt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  pftt_req_if.sink    req_i,
  pftt_tick_if.source tick_o
);

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  tick_evt_t          evt;
  buf_stat_t          stat;

  pftt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .evt_o       (evt),
    .stat_i      (stat)
  );

  pftt_ram #(
    .WIDTH  (ENTRY_W),
    .DEPTH  (MAX_FLOWS),
    .ADDR_W (IDX_W)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pftt_tick_buf u_tick_buf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .evt_i  (evt),
    .stat_o (stat),
    .tick_o (tick_o)
  );

endmodule

### design/pftt_checker.sv
module pftt_checker import pftt_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [1:0]        in_type_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [FLOW_W-1:0] out_flow_i,
  input logic              out_last_i
);

  logic              stopped_q;
  logic              open_q;
  logic [FLOW_W-1:0] prev_flow_q;
  logic              in_acc;
  logic              out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q   <= 1'b0;
      open_q      <= 1'b0;
      prev_flow_q <= '0;
    end else begin
      if (in_acc && in_type_i == REQ_STOP) begin
        stopped_q <= 1'b1;
      end
      if (out_acc) begin
        open_q      <= !out_last_i;
        prev_flow_q <= out_flow_i;
      end
    end
  end

  // held tick transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("tick dropped before it was taken");

  // table updates leave the block ready
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_type_i != REQ_TIME |=> in_ready_i)
    else $error("not ready after a table update");

  // no new ticks after stop
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> !$rose(out_valid_i))
    else $error("tick after stop");

  // ticks of one check come in rising flow order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && open_q |-> out_flow_i > prev_flow_q)
    else $error("tick flow order broken");

endmodule

bind periodic_flow_timer_table pftt_checker u_pftt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .in_type_i   (req_i.req_type),
  .out_valid_i (tick_o.valid),
  .out_ready_i (tick_o.ready),
  .out_flow_i  (tick_o.tick_flow),
  .out_last_i  (tick_o.last_tick)
);

### bench/periodic_flow_timer_table_tb.sv
module periodic_flow_timer_table_tb;
  import pftt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    req_e              kind;
    logic [FLOW_W-1:0] flow;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] now;
    logic [TAG_W-1:0]  tag;
  } timer_req_t;

  typedef struct {
    logic [FLOW_W-1:0] flow;
    logic [TAG_W-1:0]  conn;
    logic              last;
  } tick_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pftt_req_if  req_bus ();
  pftt_tick_if tick_bus ();

  periodic_flow_timer_table u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .tick_o (tick_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // timer table as the block should hold it
  logic              tbl_valid    [MAX_FLOWS];
  logic [TIME_W-1:0] tbl_period   [MAX_FLOWS];
  logic [TIME_W-1:0] tbl_deadline [MAX_FLOWS];
  logic [TAG_W-1:0]  tbl_conn     [MAX_FLOWS];
  logic              halted;

  tick_t       due_ticks[$];
  logic [63:0] cur_ns;

  int send_gap_pct;
  int recv_stall_pct;
  int hold_cycles;
  int error_count;
  int req_count;
  int tick_count;
  int busy_checks;
  int max_burst;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= 50) begin
      $display("mismatch at %0t ns: %s", $time, msg);
    end
  endtask

  function automatic void clear_table();
    foreach (tbl_valid[i]) begin
      tbl_valid[i]    = 1'b0;
      tbl_period[i]   = '0;
      tbl_deadline[i] = '0;
      tbl_conn[i]     = '0;
    end
    halted = 1'b0;
  endfunction

  // updates the table and queues the ticks one request causes
  function automatic void apply_request(input timer_req_t r);
    int    hits;
    tick_t t;
    hits = 0;
    case (r.kind)
      REQ_ADD: begin
        if (r.period != '0 && int'(r.flow) < MAX_FLOWS) begin
          tbl_period[r.flow]   = r.period;
          tbl_deadline[r.flow] = r.now + r.period;
          tbl_conn[r.flow]     = TAG_W'(r.tag[STORE_W-1:0]);
          tbl_valid[r.flow]    = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (int'(r.flow) < MAX_FLOWS) begin
          tbl_valid[r.flow] = 1'b0;
        end
      end
      REQ_STOP: begin
        halted = 1'b1;
      end
      default: begin
        if (!halted) begin
          for (int i = 0; i < MAX_FLOWS; i++) begin
            if (tbl_valid[i] && r.now >= tbl_deadline[i]) begin
              tbl_deadline[i] = tbl_deadline[i] + tbl_period[i];
              t.flow = FLOW_W'(i);
              t.conn = tbl_conn[i];
              t.last = 1'b0;
              due_ticks.push_back(t);
              hits++;
            end
          end
          if (hits > 0) begin
            t = due_ticks.pop_back();
            t.last = 1'b1;
            due_ticks.push_back(t);
            busy_checks++;
            if (hits > max_burst) begin
              max_burst = hits;
            end
          end
        end
      end
    endcase
  endfunction

  function automatic timer_req_t make_req(input req_e kind, input logic [FLOW_W-1:0] flow,
                                          input logic [63:0] period, input logic [63:0] now,
                                          input logic [TAG_W-1:0] tag);
    timer_req_t r;
    r.kind   = kind;
    r.flow   = flow;
    r.period = period;
    r.now    = now;
    r.tag    = tag;
    return r;
  endfunction

  task automatic send_request(input timer_req_t r);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk_i);
      req_bus.valid = 1'b0;
    end
    @(negedge clk_i);
    req_bus.valid      = 1'b1;
    req_bus.req_type   = r.kind;
    req_bus.flow_index = r.flow;
    req_bus.period_ns  = r.period;
    req_bus.now_ns     = r.now;
    req_bus.conn_tag   = r.tag;
    do @(posedge clk_i); while (!req_bus.ready);
    apply_request(r);
    req_count++;
  endtask

  // tick receiver with random stalls and an optional long hold-off
  initial begin : recv_ctrl
    tick_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        tick_bus.ready = 1'b0;
      end else begin
        tick_bus.ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : tick_check
    tick_t want;
    if (rst_ni && tick_bus.valid && tick_bus.ready) begin
      tick_count++;
      if (due_ticks.size() == 0) begin
        report_mismatch($sformatf("tick for flow %0d with none expected", tick_bus.tick_flow));
      end else begin
        want = due_ticks.pop_front();
        if (tick_bus.tick_flow !== want.flow) begin
          report_mismatch($sformatf("tick_flow got %0d want %0d", tick_bus.tick_flow,
                                    want.flow));
        end
        if (tick_bus.tick_conn !== want.conn) begin
          report_mismatch($sformatf("tick_conn got %h want %h (flow %0d)", tick_bus.tick_conn,
                                    want.conn, want.flow));
        end
        if (tick_bus.last_tick !== want.last) begin
          report_mismatch($sformatf("last_tick got %b want %b (flow %0d)", tick_bus.last_tick,
                                    want.last, want.flow));
        end
      end
    end
  end

  task automatic test_add_and_expire();
    send_request(make_req(REQ_ADD, 6'd0, 64'd1, 64'd0, 16'h0000));
    send_request(make_req(REQ_ADD, 6'd63, 64'd10, 64'd5, 16'hffff));
    send_request(make_req(REQ_TIME, 6'd0, 64'd0, 64'd0, 16'h0000));
    send_request(make_req(REQ_TIME, 6'd0, 64'd0, 64'd1, 16'h0000));
    send_request(make_req(REQ_TIME, 6'd0, 64'd0, 64'd15, 16'h0000));
  endtask

  task automatic test_zero_period();
    send_request(make_req(REQ_ADD, 6'd5, 64'd0, 64'd0, 16'h5a5a));
    send_request(make_req(REQ_TIME, 6'd0, 64'd0, 64'd100, 16'h0000));
  endtask

  task automatic test_overwrite();
    send_request(make_req(REQ_ADD, 6'd0, 64'd100, 64'd20, 16'h1234));
    send_request(make_req(REQ_TIME, 6'd0, 64'd0, 64'd120, 16'h0000));
  endtask

  task automatic test_remove();
    send_request(make_req(REQ_REMOVE, 6'd63, '1, '1, 16'hffff));
    send_request(make_req(REQ_REMOVE, 6'd7, 64'd0, 64'd0, 16'h0000));
    send_request(make_req(REQ_TIME, 6'd0, 64'd0, 64'd500, 16'h0000));
  endtask

  task automatic test_time_wrap();
    send_request(make_req(REQ_ADD, 6'd32, '1, '1, 16'h8001));
    send_request(make_req(REQ_ADD, 6'd1, 64'h8000_0000_0000_0000,
                          64'h8000_0000_0000_0000, 16'h7ffe));
    send_request(make_req(REQ_TIME, 6'd0, 64'd0, '1, 16'h0000));
    send_request(make_req(REQ_TIME, 6'd0, 64'd0, 64'd0, 16'h0000));
  endtask

  function automatic timer_req_t random_request();
    timer_req_t r;
    int         pick;
    int         shape;
    pick   = $urandom_range(99);
    r.flow = ($urandom_range(99) < 70) ? FLOW_W'($urandom_range(15))
                                       : FLOW_W'($urandom_range(63));
    r.tag    = TAG_W'($urandom);
    r.period = {$urandom, $urandom};
    r.now    = {$urandom, $urandom};
    if (pick < 35) begin
      r.kind = REQ_ADD;
      shape  = $urandom_range(99);
      if (shape < 5) begin
        r.period = '0;
      end else if (shape >= 15) begin
        r.period = 64'($urandom_range(2000, 1));
      end
      if ($urandom_range(9) != 0) begin
        r.now = cur_ns;
      end
    end else if (pick < 50) begin
      r.kind = REQ_REMOVE;
    end else begin
      r.kind = REQ_TIME;
      cur_ns = cur_ns + 64'($urandom_range(1500));
      if ($urandom_range(9) != 0) begin
        r.now = cur_ns;
      end
    end
    return r;
  endfunction

  task automatic test_random_traffic(input int count, input int gap_pct, input int stall_pct);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      send_request(random_request());
    end
  endtask

  // many live entries, receiver held off so the tick path backs up into the request side
  task automatic test_backpressure();
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < 16; i++) begin
      send_request(make_req(REQ_ADD, FLOW_W'(i), 64'($urandom_range(20, 1)), cur_ns,
                            TAG_W'($urandom)));
    end
    hold_cycles = 500;
    repeat (2) begin
      cur_ns = cur_ns + 64'd100;
      send_request(make_req(REQ_TIME, '0, '0, cur_ns, '0));
    end
    recv_stall_pct = 30;
  endtask

  task automatic test_stop();
    send_request(make_req(REQ_STOP, 6'd0, 64'd0, 64'd0, 16'h0000));
    send_request(make_req(REQ_TIME, 6'd0, 64'd0, '1, 16'h0000));
    send_request(make_req(REQ_ADD, 6'd63, 64'd1, 64'd0, 16'hffff));
    send_request(make_req(REQ_REMOVE, 6'd3, 64'd0, 64'd0, 16'h0000));
    send_request(make_req(REQ_TIME, 6'd0, 64'd0, '1, 16'h0000));
  endtask

  initial begin
    clear_table();
    error_count    = 0;
    req_count      = 0;
    tick_count     = 0;
    busy_checks    = 0;
    max_burst      = 0;
    hold_cycles    = 0;
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    cur_ns         = 64'd1000;

    rst_ni             = 1'b0;
    req_bus.valid      = 1'b0;
    req_bus.req_type   = REQ_TIME;
    req_bus.flow_index = '0;
    req_bus.period_ns  = '0;
    req_bus.now_ns     = '0;
    req_bus.conn_tag   = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_add_and_expire();
    test_zero_period();
    test_overwrite();
    test_remove();
    test_time_wrap();
    test_random_traffic(24, 24, 74);
    test_random_traffic(24, 74, 24);
    test_random_traffic(23, 0, 0);
    test_backpressure();
    test_stop();

    @(negedge clk_i);
    req_bus.valid = 1'b0;
    while (due_ticks.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("%0d requests sent, %0d ticks received, %0d time checks with ticks (max %0d)",
             req_count, tick_count, busy_checks, max_burst);
    $display("covered wrap, overwrite, remove, zero interval, long receiver hold-off, stop");
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d ticks still expected", due_ticks.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
